### rtl/core/mpts_pkg.sv
// Shared types, codes and constants of the multi-policy task scheduler.
package mpts_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int TIME_W        = 16;
    localparam int SLOT_IN_W     = 4;
    localparam int CFG_DATA_W    = 16;

    localparam logic [TIME_W-1:0] QUANTUM_RESET = 16'd500;

    typedef enum logic [1:0] {
        POL_FIFO = 2'd0,
        POL_RR   = 2'd1,
        POL_SJF  = 2'd2,
        POL_PSJF = 2'd3
    } t_policy;

    typedef enum logic {
        OP_ADMIT = 1'b0,
        OP_TICK  = 1'b1
    } t_opcode;

    typedef enum logic {
        CFG_POLICY  = 1'b0,
        CFG_QUANTUM = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_APPLY
    } t_state;

    typedef struct packed {
        logic admit;
        logic scan_clear;
        logic scan_issue;
        logic apply;
    } t_dp_cmd;

    typedef struct packed {
        logic scan_last;
        logic out_free;
    } t_dp_status;

endpackage

### rtl/core/multi_policy_task_scheduler.sv
// Top level of the multi-policy task scheduler: configuration registers, controller and datapath.
//
// The scheduler keeps a table of SLOTS task slots. An admit transaction (opcode 0) marks a slot
// valid and stores the ticks of work it needs; it is accepted while idle, produces no result,
// and is ignored when the slot lies beyond the table. A tick transaction (opcode 1) picks the
// slot that runs for that tick under the configured policy (FIFO, round robin, shortest job
// first or preemptive shortest job first), charges it one tick of work and of quantum, and
// delivers one result: the running slot, an idle flag and a finished flag. A tick occupies the
// block until its decision is applied: the slot table is a memory with one registered read port;
// the tick is accepted, the scan reads one slot per cycle, a further step evaluates the last
// read, and a final step applies the decision.
// The input is stalled while a tick is in progress. A finished result waits in an output
// register, so admits and the next tick are accepted while it is still held; the apply step
// of the next tick waits only if that register is still occupied. Configuration writes are
// always ready and must be issued only while the block is idle.
module multi_policy_task_scheduler #(
    parameter int SLOTS = mpts_pkg::SLOTS_DEFAULT
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    // Input transactions.
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  logic [0:0]                            i_opcode,
    input  logic [mpts_pkg::SLOT_IN_W-1:0]        i_slot,
    input  logic [mpts_pkg::TIME_W-1:0]           i_run_time,
    // Result transactions.
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output logic [mpts_pkg::SLOT_IN_W-1:0]        o_running_slot,
    output logic                                  o_idle,
    output logic                                  o_finished,
    // Configuration writes.
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [0:0]                            i_cfg_index,
    input  logic [mpts_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    mpts_pkg::t_policy                r_policy;
    logic [mpts_pkg::TIME_W-1:0]      r_time_quantum;
    mpts_pkg::t_dp_cmd                dp_cmd;
    mpts_pkg::t_dp_status             dp_status;

    // Register writes always accepted; host must write only while idle, unchecked by the block.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy       <= mpts_pkg::POL_FIFO;
            r_time_quantum <= mpts_pkg::QUANTUM_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (mpts_pkg::t_cfg_index'(i_cfg_index))
                mpts_pkg::CFG_POLICY: begin
                    r_policy <= mpts_pkg::t_policy'(i_cfg_data[1:0]);
                end
                mpts_pkg::CFG_QUANTUM: begin
                    r_time_quantum <= i_cfg_data[mpts_pkg::TIME_W-1:0];
                end
                default: begin
                    r_policy <= r_policy;
                end
            endcase
        end
    end

    // The controller sequences admits and the per-tick scan of the slot table.
    mpts_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_opcode   (i_opcode),
        .i_status   (dp_status),
        .o_in_stall (o_in_stall),
        .o_cmd      (dp_cmd)
    );

    // The datapath holds the table, the scan accumulators and the result register.
    mpts_dpath #(
        .SLOTS (SLOTS)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .i_slot         (i_slot),
        .i_run_time     (i_run_time),
        .i_policy       (r_policy),
        .i_time_quantum (r_time_quantum),
        .i_out_stall    (i_out_stall),
        .o_status       (dp_status),
        .o_out_valid    (o_out_valid),
        .o_running_slot (o_running_slot),
        .o_idle         (o_idle),
        .o_finished     (o_finished)
    );

endmodule

### rtl/core/mpts_ctrl.sv
// Sequencing state machine of the task scheduler: accepts transactions and steps a tick.
module mpts_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    input  logic [0:0]             i_opcode,
    input  mpts_pkg::t_dp_status   i_status,
    output logic                   o_in_stall,
    output mpts_pkg::t_dp_cmd      o_cmd
);

    mpts_pkg::t_state r_state;
    mpts_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mpts_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            mpts_pkg::ST_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    if (mpts_pkg::t_opcode'(i_opcode) == mpts_pkg::OP_TICK) begin
                        o_cmd.scan_clear = 1'b1;
                        n_state          = mpts_pkg::ST_SCAN;
                    end else begin
                        o_cmd.admit = 1'b1;
                    end
                end
            end
            mpts_pkg::ST_SCAN: begin
                o_cmd.scan_issue = 1'b1;
                if (i_status.scan_last) begin
                    n_state = mpts_pkg::ST_DRAIN;
                end
            end
            mpts_pkg::ST_DRAIN: begin
                // The last table read is evaluated during this cycle.
                n_state = mpts_pkg::ST_APPLY;
            end
            mpts_pkg::ST_APPLY: begin
                if (i_status.out_free) begin
                    o_cmd.apply = 1'b1;
                    n_state     = mpts_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mpts_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### rtl/core/mpts_dpath.sv
// Datapath of the task scheduler: slot table, scan accumulators, runner state and result register.
module mpts_dpath #(
    parameter int SLOTS = mpts_pkg::SLOTS_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  mpts_pkg::t_dp_cmd                   i_cmd,
    input  logic [mpts_pkg::SLOT_IN_W-1:0]      i_slot,
    input  logic [mpts_pkg::TIME_W-1:0]         i_run_time,
    input  mpts_pkg::t_policy                   i_policy,
    input  logic [mpts_pkg::TIME_W-1:0]         i_time_quantum,
    input  logic                                i_out_stall,
    output mpts_pkg::t_dp_status                o_status,
    output logic                                o_out_valid,
    output logic [mpts_pkg::SLOT_IN_W-1:0]      o_running_slot,
    output logic                                o_idle,
    output logic                                o_finished
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW = mpts_pkg::TIME_W;

    // Remaining work per slot; entries hold garbage until an admit writes them.
    logic [TW-1:0]     r_mem [SLOTS];
    logic [TW-1:0]     r_rd_data;
    logic [SLOTS-1:0]  r_slot_valid;

    // Scan address and the stage that lines up with the registered read.
    logic [SW-1:0]     r_idx;
    logic              r_stg_vld;
    logic [SW-1:0]     r_stg_idx;
    logic              r_stg_hit;

    // Scan accumulators.
    logic              r_min_found, r_aft_found, r_any_found;
    logic [SW-1:0]     r_min_idx, r_aft_idx, r_any_idx;
    logic [TW-1:0]     r_min_val, r_aft_val, r_any_val, r_last_val;

    // Runner state.
    logic [SW-1:0]     r_last_runner;
    logic              r_last_present;
    logic [TW-1:0]     r_quantum_left;

    // Result register.
    logic              r_out_valid;
    logic [mpts_pkg::SLOT_IN_W-1:0] r_out_slot;
    logic              r_out_idle;
    logic              r_out_fin;

    logic              admit_ok;
    logic              absent;
    logic              keep;
    logic              reload;
    logic              alt_found;
    logic [SW-1:0]     alt_idx;
    logic [TW-1:0]     alt_val;
    logic              found;
    logic [SW-1:0]     chosen_idx;
    logic [TW-1:0]     chosen_val;
    logic              done;
    logic [TW-1:0]     q_base;
    logic              mem_we;
    logic [SW-1:0]     mem_waddr;
    logic [TW-1:0]     mem_wdata;

    assign admit_ok = ({28'd0, i_slot} < 32'(SLOTS));
    assign absent   = !r_last_present || !r_slot_valid[r_last_runner];

    always_comb begin
        keep      = 1'b0;
        reload    = 1'b0;
        alt_found = r_min_found;
        alt_idx   = r_min_idx;
        alt_val   = r_min_val;
        case (i_policy)
            mpts_pkg::POL_FIFO: begin
                keep      = !absent;
                alt_found = r_aft_found;
                alt_idx   = r_aft_idx;
                alt_val   = r_aft_val;
            end
            mpts_pkg::POL_RR: begin
                keep   = !absent && (r_quantum_left != '0);
                reload = !keep;
                if (r_aft_found) begin
                    alt_found = 1'b1;
                    alt_idx   = r_aft_idx;
                    alt_val   = r_aft_val;
                end else begin
                    alt_found = r_any_found;
                    alt_idx   = r_any_idx;
                    alt_val   = r_any_val;
                end
            end
            mpts_pkg::POL_SJF: begin
                keep = !absent;
            end
            mpts_pkg::POL_PSJF: begin
                // The runner stays unless some slot is strictly shorter.
                keep = !absent && !(r_min_val < r_last_val);
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign found      = keep || alt_found;
    assign chosen_idx = keep ? r_last_runner : alt_idx;
    assign chosen_val = keep ? r_last_val : alt_val;
    assign done       = (chosen_val <= TW'(1));
    assign q_base     = reload ? i_time_quantum : r_quantum_left;

    assign mem_we    = (i_cmd.admit && admit_ok) || (i_cmd.apply && found && !done);
    assign mem_waddr = i_cmd.admit ? SW'(i_slot) : chosen_idx;
    assign mem_wdata = i_cmd.admit ? i_run_time : chosen_val - TW'(1);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.scan_issue) begin
            r_rd_data <= r_mem[r_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.scan_issue) begin
            r_stg_idx <= r_idx;
            r_stg_hit <= r_slot_valid[r_idx];
        end
        if (r_stg_vld) begin
            if (r_stg_idx == r_last_runner) begin
                r_last_val <= r_rd_data;
            end
            if (r_stg_hit && (!r_min_found || (r_rd_data < r_min_val))) begin
                r_min_idx <= r_stg_idx;
                r_min_val <= r_rd_data;
            end
            if (r_stg_hit && !r_any_found) begin
                r_any_idx <= r_stg_idx;
                r_any_val <= r_rd_data;
            end
            if (r_stg_hit && !r_aft_found && (!r_last_present || (r_stg_idx > r_last_runner))) begin
                r_aft_idx <= r_stg_idx;
                r_aft_val <= r_rd_data;
            end
        end
        if (i_cmd.apply) begin
            r_out_slot <= found ? mpts_pkg::SLOT_IN_W'(chosen_idx) : '0;
            r_out_idle <= !found;
            r_out_fin  <= found && done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx          <= '0;
            r_stg_vld      <= 1'b0;
            r_min_found    <= 1'b0;
            r_aft_found    <= 1'b0;
            r_any_found    <= 1'b0;
            r_slot_valid   <= '0;
            r_last_runner  <= '0;
            r_last_present <= 1'b0;
            r_quantum_left <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_stg_vld <= i_cmd.scan_issue;
            if (i_cmd.scan_clear) begin
                r_idx       <= '0;
                r_min_found <= 1'b0;
                r_aft_found <= 1'b0;
                r_any_found <= 1'b0;
            end else if (i_cmd.scan_issue) begin
                r_idx <= r_idx + SW'(1);
            end
            if (r_stg_vld && r_stg_hit) begin
                r_min_found <= 1'b1;
                r_any_found <= 1'b1;
                if (!r_last_present || (r_stg_idx > r_last_runner)) begin
                    r_aft_found <= 1'b1;
                end
            end
            if (i_cmd.admit && admit_ok) begin
                r_slot_valid[SW'(i_slot)] <= 1'b1;
            end
            if (i_cmd.apply) begin
                r_quantum_left <= found ? q_base - TW'(1) : q_base;
                if (found) begin
                    r_last_runner  <= chosen_idx;
                    r_last_present <= 1'b1;
                    if (done) begin
                        r_slot_valid[chosen_idx] <= 1'b0;
                    end
                end
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.scan_last = (r_idx == SW'(SLOTS - 1));
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid    = r_out_valid;
    assign o_running_slot = r_out_slot;
    assign o_idle         = r_out_idle;
    assign o_finished     = r_out_fin;

endmodule

### rtl/core/mpts_checker.sv
// Port-level assertions of the task scheduler and their binding to the top level.
module mpts_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic [0:0]                       i_opcode,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input logic [mpts_pkg::SLOT_IN_W-1:0]   o_running_slot,
    input logic                             o_idle,
    input logic                             o_finished
);

    // An idle result names slot zero and never reports completion.
    a_idle_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_idle) |-> ((o_running_slot == '0) && !o_finished))
        else $error("idle result carries a slot or a completion");

    // An accepted tick holds off the next input transaction while the scan runs.
    a_tick_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_opcode == mpts_pkg::OP_TICK)) |=> o_in_stall)
        else $error("input accepted right after a tick");

    // A new result appears only at the end of a tick, while the input is stalled.
    a_result_after_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without a tick in progress");

    // A stalled result stays valid and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_running_slot) && $stable(o_idle) && $stable(o_finished)))
        else $error("stalled result changed");

endmodule

bind multi_policy_task_scheduler mpts_checker u_mpts_checker (.*);
